/* hdl/ray_box_slab_intersect_assert.svh */
// assertion macros for the ray box slab intersect checker
// no dependencies; included by rbsi_checker.sv
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RBSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbsi assertion failed");

// next-cycle implication, held off during reset
`define RBSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbsi assertion failed");

`endif

/* hdl/rbsi_pkg.sv */
// shared types, constants and helpers for the ray box slab intersect block
// no dependencies
package rbsi_pkg;

    localparam int QW         = 32;
    localparam int NUM_W      = 49;
    localparam int DIV_STAGES = NUM_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [QW-1:0]    Q_MIN   = 32'h8000_0000;
    localparam logic [QW-1:0]    Q_MAX   = 32'h7fff_ffff;
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'h8000_0000);
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(64'h7fff_ffff);

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // classified ray, front to back
    typedef struct packed {
        logic [2:0][QW-1:0] org;
        logic [2:0][QW-1:0] dir;
        logic [2:0][QW:0]   lo_mag;
        logic [2:0][QW:0]   hi_mag;
        logic [2:0]         lo_neg;
        logic [2:0]         hi_neg;
        logic [2:0][QW-1:0] den_mag;
        logic [2:0]         den_neg;
        logic [2:0]         dzero;
        logic               zmiss;
    } t_item;

    // what rides beside the dividers
    typedef struct packed {
        logic [2:0][QW-1:0] org;
        logic [2:0][QW-1:0] dir;
        logic [2:0]         qneg_lo;
        logic [2:0]         qneg_hi;
        logic [2:0]         dzero;
        logic               zmiss;
    } t_side;

    typedef struct packed {
        logic push;
        logic full;
    } t_push_ctl;

    function automatic logic [QW-1:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
        logic [QW-1:0] r;
        if (neg) begin
            if (q > NEG_LIM) r = Q_MIN;
            else r = ~q[QW-1:0] + 32'd1;
        end else begin
            if (q > POS_LIM) r = Q_MAX;
            else r = q[QW-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/rbsi_front.sv */
// front end: box registers, ray classification and numerator/divisor prep
// depends on rbsi_pkg
module rbsi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [2:0]                     i_cfg_index,
    input  logic [rbsi_pkg::QW-1:0]        i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [2:0][rbsi_pkg::QW-1:0]   i_org,
    input  logic [2:0][rbsi_pkg::QW-1:0]   i_dir,
    output logic                           o_in_stall,
    output rbsi_pkg::t_push_ctl            o_ctl_unused,
    input  logic                           i_full,
    output logic                           o_push,
    output rbsi_pkg::t_item                o_item
);
    import rbsi_pkg::*;

    logic [2:0][QW-1:0] r_box_min;
    logic [2:0][QW-1:0] r_box_max;
    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic [QW:0]        diff_lo [3];
    logic [QW:0]        diff_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min <= '0;
            r_box_max <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MIN_X: r_box_min[0] <= i_cfg_data;
                REG_MIN_Y: r_box_min[1] <= i_cfg_data;
                REG_MIN_Z: r_box_min[2] <= i_cfg_data;
                REG_MAX_X: r_box_max[0] <= i_cfg_data;
                REG_MAX_Y: r_box_max[1] <= i_cfg_data;
                REG_MAX_Z: r_box_max[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_item = '0;
        for (int a = 0; a < 3; a++) begin
            diff_lo[a] = {r_box_min[a][QW-1], r_box_min[a]} - {i_org[a][QW-1], i_org[a]};
            diff_hi[a] = {r_box_max[a][QW-1], r_box_max[a]} - {i_org[a][QW-1], i_org[a]};
            n_item.org[a]     = i_org[a];
            n_item.dir[a]     = i_dir[a];
            n_item.lo_neg[a]  = diff_lo[a][QW];
            n_item.hi_neg[a]  = diff_hi[a][QW];
            n_item.lo_mag[a]  = diff_lo[a][QW] ? -diff_lo[a] : diff_lo[a];
            n_item.hi_mag[a]  = diff_hi[a][QW] ? -diff_hi[a] : diff_hi[a];
            n_item.den_neg[a] = i_dir[a][QW-1];
            n_item.den_mag[a] = i_dir[a][QW-1] ? -i_dir[a] : i_dir[a];
            n_item.dzero[a]   = (i_dir[a] == '0);
            // flat slab with the origin outside the planes
            if (n_item.dzero[a] && (($signed(i_org[a]) < $signed(r_box_min[a]))
                    || ($signed(i_org[a]) > $signed(r_box_max[a]))))
                n_item.zmiss = 1'b1;
        end
    end

    assign o_in_stall = r_valid && i_full;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;
    assign o_ctl_unused.push = o_push;
    assign o_ctl_unused.full = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* hdl/rbsi_fifo.sv */
// short queue between front and back
// depends on rbsi_pkg
module rbsi_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbsi_pkg::t_push_ctl  i_ctl,
    input  rbsi_pkg::t_item      i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output rbsi_pkg::t_item      o_item,
    output logic                 o_empty
);
    import rbsi_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop_ok;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) r_wp <= r_wp + 1'b1;
            if (pop_ok) r_rp <= r_rp + 1'b1;
            case ({i_ctl.push, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) r_mem[r_wp] <= i_item;
    end

endmodule

/* hdl/rbsi_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on rbsi_pkg
module rbsi_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rbsi_pkg::NUM_W-1:0] i_num,
    input  logic [rbsi_pkg::QW-1:0]    i_den,
    output logic [rbsi_pkg::NUM_W-1:0] o_quo
);
    import rbsi_pkg::*;

    logic [QW-1:0]    r_rem [DIV_STAGES];
    logic [NUM_W-1:0] r_nq  [DIV_STAGES];
    logic [QW-1:0]    r_den [DIV_STAGES];
    logic [QW-1:0]    s_rem [DIV_STAGES];
    logic [NUM_W-1:0] s_nq  [DIV_STAGES];
    logic [QW-1:0]    s_den [DIV_STAGES];
    logic [QW:0]      part  [DIV_STAGES];
    logic             ge    [DIV_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                s_rem[k] = '0;
                s_nq[k]  = i_num;
                s_den[k] = i_den;
            end else begin
                s_rem[k] = r_rem[k-1];
                s_nq[k]  = r_nq[k-1];
                s_den[k] = r_den[k-1];
            end
            // remainder shifted left with the next numerator bit
            part[k] = {s_rem[k], s_nq[k][NUM_W-1]};
            ge[k]   = (part[k] >= {1'b0, s_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= ge[k] ? QW'(part[k] - {1'b0, s_den[k]}) : part[k][QW-1:0];
                r_nq[k]  <= {s_nq[k][NUM_W-2:0], ge[k]};
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quo = r_nq[DIV_STAGES-1];

endmodule

/* hdl/rbsi_back.sv */
// back end: six slab dividers, interval narrowing, hit point and output register
// depends on rbsi_pkg and rbsi_div
module rbsi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbsi_pkg::t_item               i_item,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [rbsi_pkg::QW-1:0]       o_t_enter,
    output logic [rbsi_pkg::QW-1:0]       o_t_exit,
    output logic [1:0]                    o_entry_axis,
    output logic [2:0][rbsi_pkg::QW-1:0]  o_point
);
    import rbsi_pkg::*;

    localparam logic [NUM_W-1:0] SUM_MIN = {{(NUM_W-QW){1'b1}}, Q_MIN};
    localparam logic [NUM_W-1:0] SUM_MAX = {{(NUM_W-QW){1'b0}}, Q_MAX};

    logic               en;
    t_side              side_in;
    logic [NUM_W-1:0]   quo_lo [3];
    logic [NUM_W-1:0]   quo_hi [3];

    logic               r_sv   [DIV_STAGES];
    t_side              r_side [DIV_STAGES];

    logic               r_a_valid;
    t_side              r_a_side;
    logic [2:0][QW-1:0] r_a_lo;
    logic [2:0][QW-1:0] r_a_hi;

    logic               r_b_valid;
    logic [2:0][QW-1:0] r_b_org;
    logic [2:0][QW-1:0] r_b_dir;
    logic [QW-1:0]      r_b_tin;
    logic [QW-1:0]      r_b_tout;
    t_axis              r_b_ax;
    logic               r_b_miss;
    logic [QW-1:0]      r_b_lz;
    logic [QW-1:0]      r_b_hz;

    logic               r_c_valid;
    logic [2:0][QW-1:0] r_c_org;
    logic [2:0][QW-1:0] r_c_dir;
    logic [QW-1:0]      r_c_tin;
    logic [QW-1:0]      r_c_tout;
    t_axis              r_c_ax;
    logic               r_c_miss;

    logic               r_d_valid;
    logic [2:0][QW-1:0] r_d_org;
    logic [2:0][63:0]   r_d_prod;
    logic [QW-1:0]      r_d_tin;
    logic [QW-1:0]      r_d_tout;
    t_axis              r_d_ax;
    logic               r_d_miss;

    logic               r_out_valid;
    logic               r_hit;
    logic [QW-1:0]      r_t_enter;
    logic [QW-1:0]      r_t_exit;
    logic [1:0]         r_entry_axis;
    logic [2:0][QW-1:0] r_point;

    logic [QW-1:0]      n_a_lo [3];
    logic [QW-1:0]      n_a_hi [3];
    logic [QW-1:0]      sl [2];
    logic [QW-1:0]      sh [2];
    logic [QW-1:0]      n_b_tin;
    logic [QW-1:0]      n_b_tout;
    t_axis              n_b_ax;
    logic               n_b_miss;
    logic [QW-1:0]      lz;
    logic [QW-1:0]      hz;
    logic [QW-1:0]      n_c_tin;
    logic [QW-1:0]      n_c_tout;
    t_axis              n_c_ax;
    logic               n_c_miss;
    logic [63:0]        shifted [3];
    logic [NUM_W-1:0]   psum [3];
    logic [QW-1:0]      n_point [3];

    // the whole back pipeline moves whenever the output register frees up
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_empty;

    always_comb begin
        side_in.org     = i_item.org;
        side_in.dir     = i_item.dir;
        side_in.qneg_lo = i_item.lo_neg ^ i_item.den_neg;
        side_in.qneg_hi = i_item.hi_neg ^ i_item.den_neg;
        side_in.dzero   = i_item.dzero;
        side_in.zmiss   = i_item.zmiss;
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div u_div_lo (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({i_item.lo_mag[a], 16'd0}),
            .i_den (i_item.den_mag[a]),
            .o_quo (quo_lo[a])
        );
        rbsi_div u_div_hi (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({i_item.hi_mag[a], 16'd0}),
            .i_den (i_item.den_mag[a]),
            .o_quo (quo_hi[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_sv[k] <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= o_pop;
            for (int k = 1; k < DIV_STAGES; k++) r_sv[k] <= r_sv[k-1];
            r_a_valid   <= r_sv[DIV_STAGES-1];
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_out_valid <= r_d_valid;
        end
    end

    // signed quotients, saturated, flat slabs opened to the full range
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_side[DIV_STAGES-1].dzero[a]) begin
                n_a_lo[a] = Q_MIN;
                n_a_hi[a] = Q_MAX;
            end else begin
                n_a_lo[a] = sat_quo(quo_lo[a], r_side[DIV_STAGES-1].qneg_lo[a]);
                n_a_hi[a] = sat_quo(quo_hi[a], r_side[DIV_STAGES-1].qneg_hi[a]);
            end
        end
    end

    // order x and y slabs, merge them
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if ($signed(r_a_lo[a]) > $signed(r_a_hi[a])) begin
                sl[a] = r_a_hi[a];
                sh[a] = r_a_lo[a];
            end else begin
                sl[a] = r_a_lo[a];
                sh[a] = r_a_hi[a];
            end
        end
        if ($signed(r_a_lo[2]) > $signed(r_a_hi[2])) begin
            lz = r_a_hi[2];
            hz = r_a_lo[2];
        end else begin
            lz = r_a_lo[2];
            hz = r_a_hi[2];
        end
        n_b_miss = r_a_side.zmiss || ($signed(sl[0]) > $signed(sh[1]))
                   || ($signed(sl[1]) > $signed(sh[0]));
        n_b_tin  = sl[0];
        n_b_ax   = AXIS_X;
        if ($signed(sl[1]) > $signed(sl[0])) begin
            n_b_tin = sl[1];
            n_b_ax  = AXIS_Y;
        end
        n_b_tout = ($signed(sh[1]) < $signed(sh[0])) ? sh[1] : sh[0];
    end

    // fold in the z slab
    always_comb begin
        n_c_miss = r_b_miss || ($signed(r_b_tin) > $signed(r_b_hz))
                   || ($signed(r_b_lz) > $signed(r_b_tout));
        n_c_tin  = r_b_tin;
        n_c_ax   = r_b_ax;
        if ($signed(r_b_lz) > $signed(r_b_tin)) begin
            n_c_tin = r_b_lz;
            n_c_ax  = AXIS_Z;
        end
        n_c_tout = ($signed(r_b_hz) < $signed(r_b_tout)) ? r_b_hz : r_b_tout;
    end

    // hit point: floor of the product by 2^16, plus origin, saturated
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            shifted[a] = 64'($signed(r_d_prod[a]) >>> 16);
            psum[a]    = {{(NUM_W-QW){r_d_org[a][QW-1]}}, r_d_org[a]} + shifted[a][NUM_W-1:0];
            if ($signed(psum[a]) < $signed(SUM_MIN)) n_point[a] = Q_MIN;
            else if ($signed(psum[a]) > $signed(SUM_MAX)) n_point[a] = Q_MAX;
            else n_point[a] = psum[a][QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side_in;
            for (int k = 1; k < DIV_STAGES; k++) r_side[k] <= r_side[k-1];

            r_a_side <= r_side[DIV_STAGES-1];
            for (int a = 0; a < 3; a++) begin
                r_a_lo[a] <= n_a_lo[a];
                r_a_hi[a] <= n_a_hi[a];
            end

            r_b_org  <= r_a_side.org;
            r_b_dir  <= r_a_side.dir;
            r_b_tin  <= n_b_tin;
            r_b_tout <= n_b_tout;
            r_b_ax   <= n_b_ax;
            r_b_miss <= n_b_miss;
            r_b_lz   <= lz;
            r_b_hz   <= hz;

            r_c_org  <= r_b_org;
            r_c_dir  <= r_b_dir;
            r_c_tin  <= n_c_tin;
            r_c_tout <= n_c_tout;
            r_c_ax   <= n_c_ax;
            r_c_miss <= n_c_miss;

            r_d_org  <= r_c_org;
            for (int a = 0; a < 3; a++) begin
                r_d_prod[a] <= 64'($signed(r_c_tin) * $signed(r_c_dir[a]));
            end
            r_d_tin  <= r_c_tin;
            r_d_tout <= r_c_tout;
            r_d_ax   <= r_c_ax;
            r_d_miss <= r_c_miss;

            r_hit        <= !r_d_miss;
            r_t_enter    <= r_d_miss ? '0 : r_d_tin;
            r_t_exit     <= r_d_miss ? '0 : r_d_tout;
            r_entry_axis <= r_d_miss ? 2'd0 : 2'(r_d_ax);
            for (int a = 0; a < 3; a++) begin
                r_point[a] <= r_d_miss ? '0 : n_point[a];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_t_enter    = r_t_enter;
    assign o_t_exit     = r_t_exit;
    assign o_entry_axis = r_entry_axis;
    assign o_point      = r_point;

endmodule

/* hdl/ray_box_slab_intersect.sv */
// top level of the ray versus axis-aligned box slab test
// depends on rbsi_pkg, rbsi_front, rbsi_fifo, rbsi_back
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  ray in   | i_in_valid / o_in_stall   | i_origin_x/y/z, i_dir_x/y/z
//  result   | o_out_valid / i_out_stall | o_hit, o_t_enter, o_t_exit,
//           |                           | o_entry_axis, o_point_x/y/z
//
// one ray per cycle sustained while the result is not stalled; the path is:
// one front stage, one queue slot, 49 divider stages (one quotient bit each),
// four narrowing and hit point stages and the output register
// synchronous active-low reset clears box registers to zero and empties the queue
// a stalled result freezes the back pipeline; the front keeps taking rays
// until the four-entry queue fills
module ray_box_slab_intersect (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [rbsi_pkg::QW-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [rbsi_pkg::QW-1:0] i_origin_x,
    input  logic [rbsi_pkg::QW-1:0] i_origin_y,
    input  logic [rbsi_pkg::QW-1:0] i_origin_z,
    input  logic [rbsi_pkg::QW-1:0] i_dir_x,
    input  logic [rbsi_pkg::QW-1:0] i_dir_y,
    input  logic [rbsi_pkg::QW-1:0] i_dir_z,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_hit,
    output logic [rbsi_pkg::QW-1:0] o_t_enter,
    output logic [rbsi_pkg::QW-1:0] o_t_exit,
    output logic [1:0]              o_entry_axis,
    output logic [rbsi_pkg::QW-1:0] o_point_x,
    output logic [rbsi_pkg::QW-1:0] o_point_y,
    output logic [rbsi_pkg::QW-1:0] o_point_z
);
    import rbsi_pkg::*;

    t_item              fr_item;
    t_item              q_item;
    t_push_ctl          push_ctl;
    logic               fr_push;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic [2:0][QW-1:0] point;

    assign o_cfg_ready = 1'b1;

    rbsi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_org        ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir        ({i_dir_z, i_dir_y, i_dir_x}),
        .o_in_stall   (o_in_stall),
        .o_ctl_unused (push_ctl),
        .i_full       (q_full),
        .o_push       (fr_push),
        .o_item       (fr_item)
    );

    rbsi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (push_ctl),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    rbsi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_empty      (q_empty || !(fr_push || !q_empty)),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_t_enter    (o_t_enter),
        .o_t_exit     (o_t_exit),
        .o_entry_axis (o_entry_axis),
        .o_point      (point)
    );

    assign o_point_x = point[0];
    assign o_point_y = point[1];
    assign o_point_z = point[2];

endmodule

/* hdl/rbsi_checker.sv */
// port-level checks for ray_box_slab_intersect, bound to the top level
// depends on ray_box_slab_intersect_assert.svh
`include "ray_box_slab_intersect_assert.svh"

module rbsi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_hit,
    input logic [31:0] o_t_enter,
    input logic [31:0] o_t_exit,
    input logic [1:0]  o_entry_axis,
    input logic [31:0] o_point_x,
    input logic [31:0] o_point_y,
    input logic [31:0] o_point_z
);

    // a stalled result stays offered
    `RBSI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a miss carries all-zero fields
    `RBSI_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_hit, (o_t_enter == 32'd0) && (o_t_exit == 32'd0) && (o_entry_axis == 2'd0) && (o_point_x == 32'd0) && (o_point_y == 32'd0) && (o_point_z == 32'd0))

    // a hit has an ordered interval and a real axis
    `RBSI_ASSERT_NOW(a_hit_order, i_clk, i_rst_n, o_out_valid && o_hit, ($signed(o_t_enter) <= $signed(o_t_exit)) && (o_entry_axis != 2'd3))

    // nothing is offered right after reset
    `RBSI_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_hit        (o_hit),
    .o_t_enter    (o_t_enter),
    .o_t_exit     (o_t_exit),
    .o_entry_axis (o_entry_axis),
    .o_point_x    (o_point_x),
    .o_point_y    (o_point_y),
    .o_point_z    (o_point_z)
);
